// File: rtl/core/bptm_pkg.sv
`timescale 1ns / 1ps

package bptm_pkg;

	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_CHECK  = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_BAD_NUM  = 2'd2;

	// Per-cell control for one request
	typedef struct packed {
		logic set;   // load address, mark active
		logic clr;   // mark inactive
		logic pop;   // free stack shifts towards the top
		logic push;  // free stack shifts away from the top
	} cell_ctl_t;

endpackage

// File: rtl/core/bptm_cell.sv
`timescale 1ns / 1ps

module bptm_cell
	import bptm_pkg::*;
#(
	parameter int SW    = 4,
	parameter int INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  logic [31:0]   bp_address,
	input  logic [31:0]   exec_pc,
	input  logic [SW-1:0] stk_prev,
	input  logic [SW-1:0] stk_next,
	input  logic          hit_in,
	output logic [SW-1:0] stk_q,
	output logic          active_q,
	output logic          hit_out
);

	logic [31:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			stk_q    <= SW'(INDEX);
		end else begin
			if (ctl.set) begin
				active_q <= 1'b1;
			end else if (ctl.clr) begin
				active_q <= 1'b0;
			end
			if (ctl.pop) begin
				stk_q <= stk_next;
			end else if (ctl.push) begin
				stk_q <= stk_prev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.set) begin
			addr_q <= bp_address;
		end
	end

	assign hit_out = hit_in | (active_q & (addr_q == exec_pc));

endmodule

// File: rtl/core/breakpoint_table_match.sv
`timescale 1ns / 1ps

// Breakpoint table: a pool of NUM_SLOTS slots, one cell per slot.
// Input channel (in_valid / in_stall) carries one request: command, bp_address,
// exec_pc, bp_number and running. Create takes the slot on top of the free
// stack and returns its number (slot plus NUMBER_OFFSET); delete gives a slot
// back to the top of the stack; check compares exec_pc with every active slot.
// Output channel (out_valid / out_stall) carries status, assigned_number, hit
// and stop, one result per request.
// The result is registered: it is loaded into the output register when the
// request is accepted. Throughput is one request per cycle while the output
// is not stalled; the cells update their slot and free-stack entries in the
// accepting cycle and the match result ripples through the row of cells in
// the same cycle. A stalled result holds in the output register and in_stall
// is raised until it is taken.
// Reset clears all slots to inactive, fills the free stack with slots in
// ascending order (slot 0 first) and empties the output register. No request
// is lost or needs a clearing pass.
module breakpoint_table_match
	import bptm_pkg::*;
#(
	parameter int NUM_SLOTS     = 16,
	parameter int NUMBER_OFFSET = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] bp_address,
	input  logic [31:0] exec_pc,
	input  logic [5:0]  bp_number,
	input  logic        running,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  assigned_number,
	output logic        hit,
	output logic        stop
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [9:0] OFF_W   = 10'(NUMBER_OFFSET);
	localparam logic [9:0] SLOTS_W = 10'(NUM_SLOTS);
	localparam logic [CW-1:0] COUNT_FULL = CW'(NUM_SLOTS);

	logic            accept;
	logic            out_valid_q;
	logic [CW-1:0]   free_count_q;
	logic [SW-1:0]   stk    [NUM_SLOTS];
	logic            active [NUM_SLOTS];
	logic            hit_c  [NUM_SLOTS+1];
	cell_ctl_t       ctl    [NUM_SLOTS];

	logic            is_create, is_delete;
	logic            create_ok, delete_ok;
	logic [SW-1:0]   top_slot, del_slot;
	logic [9:0]      num_ext, num_rel, assigned_sum;

	logic [1:0]      status_d;
	logic [5:0]      assigned_d;
	logic            hit_d;

	logic [1:0]      status_q;
	logic [5:0]      assigned_q;
	logic            hit_q, stop_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign is_create = (command == CMD_CREATE);
	assign is_delete = (command == CMD_DELETE);

	assign top_slot  = stk[0];
	assign create_ok = (free_count_q != '0) &&
		({1'b0, top_slot} < (SW+1)'(NUM_SLOTS));

	assign num_ext  = {4'b0, bp_number};
	assign num_rel  = num_ext - OFF_W;
	assign del_slot = num_rel[SW-1:0];
	assign delete_ok = (num_ext >= OFF_W) && (num_rel < SLOTS_W) &&
		active[del_slot] && (free_count_q < COUNT_FULL);

	assign assigned_sum = {{(10-SW){1'b0}}, top_slot} + OFF_W;

	generate
		for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
			logic [SW-1:0] prev_w, next_w;

			if (k == 0) begin : g_first
				assign prev_w = del_slot;
			end else begin : g_mid_p
				assign prev_w = stk[k-1];
			end
			if (k == NUM_SLOTS - 1) begin : g_last
				assign next_w = stk[k];
			end else begin : g_mid_n
				assign next_w = stk[k+1];
			end

			always_comb begin
				ctl[k].set  = accept & is_create & create_ok & (top_slot == SW'(k));
				ctl[k].clr  = accept & is_delete & delete_ok & (del_slot == SW'(k));
				ctl[k].pop  = accept & is_create & create_ok;
				ctl[k].push = accept & is_delete & delete_ok;
			end

			bptm_cell #(
				.SW    (SW),
				.INDEX (k)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl[k]),
				.bp_address (bp_address),
				.exec_pc    (exec_pc),
				.stk_prev   (prev_w),
				.stk_next   (next_w),
				.hit_in     (hit_c[k]),
				.stk_q      (stk[k]),
				.active_q   (active[k]),
				.hit_out    (hit_c[k+1])
			);
		end
	endgenerate

	assign hit_c[0] = 1'b0;

	always_comb begin
		status_d   = STATUS_OK;
		assigned_d = '0;
		hit_d      = 1'b0;
		case (command)
			CMD_CREATE: begin
				if (create_ok) begin
					assigned_d = assigned_sum[5:0];
					hit_d      = (bp_address == exec_pc);
				end else begin
					status_d = STATUS_FULL;
				end
			end
			CMD_DELETE: begin
				if (!delete_ok) begin
					status_d = STATUS_BAD_NUM;
				end
			end
			CMD_CHECK: begin
				hit_d = hit_c[NUM_SLOTS];
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= COUNT_FULL;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept && is_create && create_ok) begin
				free_count_q <= free_count_q - CW'(1);
			end else if (accept && is_delete && delete_ok) begin
				free_count_q <= free_count_q + CW'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result while the receiver stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status_d;
			assigned_q <= assigned_d;
			hit_q      <= hit_d;
			stop_q     <= hit_d & running;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign assigned_number = assigned_q;
	assign hit             = hit_q;
	assign stop            = stop_q;

endmodule

// File: rtl/core/bptm_checker.sv
`timescale 1ns / 1ps

module bptm_checker
	import bptm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [5:0]  assigned_number,
	input logic        hit,
	input logic        stop
);

	// An accepted request always lands in the output register
	a_accept_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted request produced no result");

	// Stall only while a result is held back
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with no held result");

	// A failed request never reports a match or a stop and returns number zero
	a_fail_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STATUS_OK) |-> (!hit && !stop && assigned_number == 6'd0))
		else $error("failed request reported a match");

	// Held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(hit)))
		else $error("stalled result changed");

endmodule

bind breakpoint_table_match bptm_checker u_bptm_checker (.*);

// File: verif/breakpoint_table_match_tb.sv
`timescale 1ns / 1ps

module testbench
	import bptm_pkg::*;
();

	localparam int NUM_SLOTS     = 16;
	localparam int NUMBER_OFFSET = 32;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int DIR_ROWS      = 24;
	localparam int RANDOM_ITEMS  = 1880;
	localparam int IDLE_LIMIT    = 2000;
	localparam int TAIL_CYCLES   = 8;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] number;
		logic       hit;
		logic       stop;
	} bp_reply_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] addr;
		logic [31:0] pc;
		logic [5:0]  num;
		logic        run;
		logic [7:0]  reps;
		logic        typed;
		bp_reply_t   reply;
	} bp_stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [31:0] bp_address;
	logic [31:0] exec_pc;
	logic [5:0]  bp_number;
	logic        running;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [5:0]  assigned_number;
	logic        hit;
	logic        stop;

	// Shadow copy of the breakpoint pool
	logic [31:0] shadow_addr [NUM_SLOTS];
	bit          shadow_active [NUM_SLOTS];
	logic [3:0]  shadow_free [NUM_SLOTS];
	logic [4:0]  shadow_free_cnt;

	bp_reply_t    replies_due [$];
	bp_stim_row_t bp_rows [DIR_ROWS];
	int           err_count;
	int           idle_cycles;
	bit           row_typed;
	bp_reply_t    row_reply;

	breakpoint_table_match #(
		.NUM_SLOTS     (NUM_SLOTS),
		.NUMBER_OFFSET (NUMBER_OFFSET)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.bp_address      (bp_address),
		.exec_pc         (exec_pc),
		.bp_number       (bp_number),
		.running         (running),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.assigned_number (assigned_number),
		.hit             (hit),
		.stop            (stop)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		err_count++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic clear_pool();
		for (int k = 0; k < NUM_SLOTS; k++) begin
			shadow_addr[k]   = '0;
			shadow_active[k] = 1'b0;
			shadow_free[k]   = 4'(k);
		end
		shadow_free_cnt = 5'(NUM_SLOTS);
	endtask

	function automatic bp_reply_t predict_bp_reply(input logic [1:0] cmd, input logic [31:0] addr,
			input logic [31:0] pc, input logic [5:0] num, input logic run);
		bp_reply_t r;
		int slot;
		r = '0;
		case (cmd)
			CMD_CREATE: begin
				slot = NUM_SLOTS;
				if (shadow_free_cnt > 0 && shadow_free_cnt <= NUM_SLOTS)
					slot = shadow_free[NUM_SLOTS - shadow_free_cnt];
				if (slot >= NUM_SLOTS) begin
					r.status = STATUS_FULL;
				end else begin
					shadow_free_cnt    = shadow_free_cnt - 5'd1;
					shadow_addr[slot]   = addr;
					shadow_active[slot] = 1'b1;
					r.number = 6'(slot + NUMBER_OFFSET);
					r.hit    = (addr == pc);
				end
			end
			CMD_DELETE: begin
				slot = int'(num) - NUMBER_OFFSET;
				if (slot < 0 || slot >= NUM_SLOTS || !shadow_active[slot] ||
						shadow_free_cnt >= NUM_SLOTS) begin
					r.status = STATUS_BAD_NUM;
				end else begin
					shadow_active[slot] = 1'b0;
					shadow_free_cnt    = shadow_free_cnt + 5'd1;
					shadow_free[NUM_SLOTS - shadow_free_cnt] = 4'(slot);
				end
			end
			CMD_CHECK: begin
				for (int k = 0; k < NUM_SLOTS; k++)
					if (shadow_active[k] && shadow_addr[k] == pc)
						r.hit = 1'b1;
			end
			default: ;
		endcase
		r.stop = r.hit & run;
		return r;
	endfunction

	function automatic bp_reply_t reply(input logic [1:0] st, input logic [5:0] n,
			input logic h, input logic s);
		return {st, n, h, s};
	endfunction

	function automatic bp_stim_row_t make_row(input logic [1:0] cmd, input logic [31:0] addr,
			input logic [31:0] pc, input logic [5:0] num, input logic run, input logic [7:0] reps,
			input logic typed, input bp_reply_t r);
		return {cmd, addr, pc, num, run, reps, typed, r};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	task automatic issue_request(input logic [1:0] cmd, input logic [31:0] addr,
			input logic [31:0] pc, input logic [5:0] num, input logic run, input int gap,
			input logic typed, input bp_reply_t r);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		bp_address <= addr;
		exec_pc    <= pc;
		bp_number  <= num;
		running    <= run;
		row_typed  <= typed;
		row_reply  <= r;
		@(posedge clk);
		while (!(in_valid && !in_stall))
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result checker, request predictor and watchdog
	always @(posedge clk) begin : monitor
		bp_reply_t got;
		bp_reply_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = {status, assigned_number, hit, stop};
				if (replies_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h", got));
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status)
						flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
					if (got.number !== want.number)
						flag_mismatch($sformatf("assigned_number %0d, want %0d",
							got.number, want.number));
					if (got.hit !== want.hit)
						flag_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
					if (got.stop !== want.stop)
						flag_mismatch($sformatf("stop %b, want %b", got.stop, want.stop));
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				want = predict_bp_reply(command, bp_address, exec_pc, bp_number, running);
				replies_due.push_back(row_typed ? row_reply : want);
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Result-side back-pressure: runs of stall and free flow, mostly short
	initial begin : sink
		int r;
		int len;
		logic level;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(99);
			if (r < 15) begin
				level = 1'b0;
				len   = $urandom_range(60, 30);
			end else if (r < 60) begin
				level = 1'b0;
				len   = $urandom_range(4, 1);
			end else if (r < 92) begin
				level = 1'b1;
				len   = $urandom_range(3, 1);
			end else begin
				level = 1'b1;
				len   = $urandom_range(25, 10);
			end
			repeat (len) begin
				@(negedge clk);
				out_stall <= level;
			end
		end
	end

	initial begin : source
		int act [$];
		int sel;
		int gap;
		bit create_heavy;
		logic [1:0]  cmd;
		logic [31:0] addr;
		logic [31:0] pc;
		logic [5:0]  num;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CMD_CHECK;
		bp_address  = '0;
		exec_pc     = '0;
		bp_number   = '0;
		running     = 1'b0;
		row_typed   = 1'b0;
		row_reply   = '0;
		err_count   = 0;
		idle_cycles = 0;
		clear_pool();

		bp_rows[0]  = make_row(CMD_CHECK, 32'h0, 32'h0, 6'd0, 1'b1, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd0, 1'b0, 1'b0));
		bp_rows[1]  = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd32, 1'b0, 8'd1, 1'b1,
			reply(STATUS_BAD_NUM, 6'd0, 1'b0, 1'b0));
		bp_rows[2]  = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd0, 1'b0, 8'd1, 1'b1,
			reply(STATUS_BAD_NUM, 6'd0, 1'b0, 1'b0));
		bp_rows[3]  = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd63, 1'b1, 8'd1, 1'b1,
			reply(STATUS_BAD_NUM, 6'd0, 1'b0, 1'b0));
		bp_rows[4]  = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd48, 1'b0, 8'd1, 1'b1,
			reply(STATUS_BAD_NUM, 6'd0, 1'b0, 1'b0));
		bp_rows[5]  = make_row(CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1'b1, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd32, 1'b1, 1'b1));
		bp_rows[6]  = make_row(CMD_CREATE, 32'h0, 32'hFFFF_FFFF, 6'd0, 1'b0, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd33, 1'b0, 1'b0));
		bp_rows[7]  = make_row(CMD_CHECK, 32'h0, 32'h0, 6'd0, 1'b1, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd0, 1'b1, 1'b1));
		bp_rows[8]  = make_row(CMD_CHECK, 32'h0, 32'hFFFF_FFFF, 6'd0, 1'b0, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd0, 1'b1, 1'b0));
		bp_rows[9]  = make_row(CMD_CHECK, 32'h0, 32'h5555_5555, 6'd0, 1'b1, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd0, 1'b0, 1'b0));
		bp_rows[10] = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd32, 1'b0, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd0, 1'b0, 1'b0));
		bp_rows[11] = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd32, 1'b0, 8'd1, 1'b1,
			reply(STATUS_BAD_NUM, 6'd0, 1'b0, 1'b0));
		bp_rows[12] = make_row(CMD_CREATE, 32'h1234_5678, 32'h1234_5678, 6'd0, 1'b0, 8'd1, 1'b0,
			'0);
		bp_rows[13] = make_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd0, 1'b0, 1'b0));
		// fill the rest of the pool
		bp_rows[14] = make_row(CMD_CREATE, 32'h8000_0000, 32'h7FFF_FFFF, 6'd0, 1'b1, 8'd14, 1'b0,
			'0);
		bp_rows[15] = make_row(CMD_CREATE, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 6'd0, 1'b1, 8'd1, 1'b1,
			reply(STATUS_FULL, 6'd0, 1'b0, 1'b0));
		bp_rows[16] = make_row(CMD_CHECK, 32'h0, 32'h8000_0000, 6'd0, 1'b1, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd0, 1'b1, 1'b1));
		bp_rows[17] = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd47, 1'b0, 8'd1, 1'b1,
			reply(STATUS_OK, 6'd0, 1'b0, 1'b0));
		bp_rows[18] = make_row(CMD_CREATE, 32'h0, 32'h0, 6'd0, 1'b1, 8'd1, 1'b0, '0);
		bp_rows[19] = make_row(CMD_CHECK, 32'h0, 32'h1234_5678, 6'd0, 1'b1, 8'd1, 1'b0, '0);
		bp_rows[20] = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd33, 1'b1, 8'd1, 1'b0, '0);
		bp_rows[21] = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd33, 1'b1, 8'd1, 1'b1,
			reply(STATUS_BAD_NUM, 6'd0, 1'b0, 1'b0));
		bp_rows[22] = make_row(CMD_DELETE, 32'h0, 32'h0, 6'd31, 1'b0, 8'd1, 1'b1,
			reply(STATUS_BAD_NUM, 6'd0, 1'b0, 1'b0));
		bp_rows[23] = make_row(CMD_CHECK, 32'h0, 32'hFFFF_FFFF, 6'd0, 1'b1, 8'd1, 1'b0, '0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (bp_rows[i])
			for (int n = 0; n < bp_rows[i].reps; n++)
				issue_request(bp_rows[i].cmd, bp_rows[i].addr, bp_rows[i].pc, bp_rows[i].num,
					bp_rows[i].run, pick_gap(), bp_rows[i].typed, bp_rows[i].reply);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// alternate fill and drain phases so the pool reaches both full and empty
			create_heavy = ((i / 120) % 2) == 0;
			act.delete();
			for (int k = 0; k < NUM_SLOTS; k++)
				if (shadow_active[k])
					act.push_back(k);
			sel = $urandom_range(99);
			if (create_heavy)
				cmd = (sel < 55) ? CMD_CREATE : (sel < 75) ? CMD_DELETE :
					(sel < 95) ? CMD_CHECK : CMD_UNUSED;
			else
				cmd = (sel < 20) ? CMD_CREATE : (sel < 65) ? CMD_DELETE :
					(sel < 95) ? CMD_CHECK : CMD_UNUSED;

			case ($urandom_range(3))
				0: addr = $urandom;
				1: addr = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0;
				default: addr = 32'h0000_1000 + 32'(4 * $urandom_range(7));
			endcase
			sel = $urandom_range(9);
			if (cmd == CMD_CHECK && act.size() > 0 && sel < 6)
				pc = shadow_addr[act[$urandom_range(act.size() - 1)]];
			else if (cmd == CMD_CREATE && sel < 3)
				pc = addr;
			else if (sel < 7)
				pc = 32'h0000_1000 + 32'(4 * $urandom_range(7));
			else
				pc = $urandom;
			if (act.size() > 0 && $urandom_range(9) < 7)
				num = 6'(act[$urandom_range(act.size() - 1)] + NUMBER_OFFSET);
			else
				num = 6'($urandom_range(63));

			gap = ((i % 300) < 40) ? 0 : pick_gap();
			issue_request(cmd, addr, pc, num, 1'($urandom_range(1)), gap, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (replies_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", replies_due.size()));
		if (err_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// File: breakpoint_table_match.f
rtl/core/bptm_pkg.sv
rtl/core/bptm_cell.sv
rtl/core/breakpoint_table_match.sv
rtl/core/bptm_checker.sv
verif/breakpoint_table_match_tb.sv
